@@ src/bpf_pkg.sv @@
package bpf_pkg;

  localparam int CoordW = 16;
  localparam int OutW = 24;
  localparam int CntW = 7;
  localparam int TW = 17;
  localparam int WW = 49;
  localparam int SumW = 64;
  localparam int MaxSegs = 64;
  localparam int SegsReset = 8;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [TW-1:0] tpar_t;
  typedef logic [WW-1:0] weight_t;
  typedef logic [SumW-1:0] sum_t;

  typedef enum logic [1:0] {
    ACT_MOVE  = 2'd0,
    ACT_LINE  = 2'd1,
    ACT_QUAD  = 2'd2,
    ACT_CUBIC = 2'd3
  } action_t;

  // One classified command: points in offset binary, step of t per segment
  typedef struct packed {
    logic         quad;
    logic         cs;
    cnt_t         n;
    tpar_t        q;
    cnt_t         r;
    coord_t [3:0] px;
    coord_t [3:0] py;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

  // floor(65536 / n) for n in 1..64
  function automatic tpar_t seg_step(input cnt_t n);
    tpar_t q;
    begin
      case (n)
        7'd1: q = 17'd65536;  7'd2: q = 17'd32768;  7'd3: q = 17'd21845;
        7'd4: q = 17'd16384;  7'd5: q = 17'd13107;  7'd6: q = 17'd10922;
        7'd7: q = 17'd9362;   7'd8: q = 17'd8192;   7'd9: q = 17'd7281;
        7'd10: q = 17'd6553;  7'd11: q = 17'd5957;  7'd12: q = 17'd5461;
        7'd13: q = 17'd5041;  7'd14: q = 17'd4681;  7'd15: q = 17'd4369;
        7'd16: q = 17'd4096;  7'd17: q = 17'd3855;  7'd18: q = 17'd3640;
        7'd19: q = 17'd3449;  7'd20: q = 17'd3276;  7'd21: q = 17'd3120;
        7'd22: q = 17'd2978;  7'd23: q = 17'd2849;  7'd24: q = 17'd2730;
        7'd25: q = 17'd2621;  7'd26: q = 17'd2520;  7'd27: q = 17'd2427;
        7'd28: q = 17'd2340;  7'd29: q = 17'd2259;  7'd30: q = 17'd2184;
        7'd31: q = 17'd2114;  7'd32: q = 17'd2048;  7'd33: q = 17'd1985;
        7'd34: q = 17'd1927;  7'd35: q = 17'd1872;  7'd36: q = 17'd1820;
        7'd37: q = 17'd1771;  7'd38: q = 17'd1724;  7'd39: q = 17'd1680;
        7'd40: q = 17'd1638;  7'd41: q = 17'd1598;  7'd42: q = 17'd1560;
        7'd43: q = 17'd1524;  7'd44: q = 17'd1489;  7'd45: q = 17'd1456;
        7'd46: q = 17'd1424;  7'd47: q = 17'd1394;  7'd48: q = 17'd1365;
        7'd49: q = 17'd1337;  7'd50: q = 17'd1310;  7'd51: q = 17'd1285;
        7'd52: q = 17'd1260;  7'd53: q = 17'd1236;  7'd54: q = 17'd1213;
        7'd55: q = 17'd1191;  7'd56: q = 17'd1170;  7'd57: q = 17'd1149;
        7'd58: q = 17'd1129;  7'd59: q = 17'd1110;  7'd60: q = 17'd1092;
        7'd61: q = 17'd1074;  7'd62: q = 17'd1057;  7'd63: q = 17'd1040;
        default: q = 17'd1024;
      endcase
      return q;
    end
  endfunction

endpackage

@@ src/bpf_front.sv @@
module bpf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic signed [15:0]  ctrl1_x,
  input  logic signed [15:0]  ctrl1_y,
  input  logic signed [15:0]  ctrl2_x,
  input  logic signed [15:0]  ctrl2_y,
  input  logic signed [15:0]  end_x,
  input  logic signed [15:0]  end_y,
  input  logic                segs_we,
  input  logic [6:0]          segs_data,
  input  bpf_pkg::fifo_stat_t fstat,
  output logic                push,
  output bpf_pkg::cmd_t       cmd
);

  bpf_pkg::cnt_t   segs;
  bpf_pkg::coord_t pen_x;
  bpf_pkg::coord_t pen_y;
  bpf_pkg::cnt_t   n_eff;
  bpf_pkg::tpar_t  q_step;
  logic [23:0]     qn;
  bpf_pkg::tpar_t  r_full;
  bpf_pkg::coord_t c1x, c1y, c2x, c2y, ex, ey;

  assign in_stall = fstat.full;
  assign push     = in_valid && !fstat.full;

  // offset binary: flip the sign bit
  assign c1x = {~ctrl1_x[15], ctrl1_x[14:0]};
  assign c1y = {~ctrl1_y[15], ctrl1_y[14:0]};
  assign c2x = {~ctrl2_x[15], ctrl2_x[14:0]};
  assign c2y = {~ctrl2_y[15], ctrl2_y[14:0]};
  assign ex  = {~end_x[15], end_x[14:0]};
  assign ey  = {~end_y[15], end_y[14:0]};

  always_comb begin
    if (segs == '0) begin
      n_eff = 7'd1;
    end else if (segs > bpf_pkg::cnt_t'(bpf_pkg::MaxSegs)) begin
      n_eff = bpf_pkg::cnt_t'(bpf_pkg::MaxSegs);
    end else begin
      n_eff = segs;
    end
  end

  assign q_step = bpf_pkg::seg_step(n_eff);
  assign qn     = {7'd0, q_step} * {17'd0, n_eff};
  assign r_full = 17'd65536 - qn[16:0];

  always_comb begin
    cmd.quad  = 1'b0;
    cmd.cs    = 1'b0;
    cmd.n     = n_eff;
    cmd.q     = q_step;
    cmd.r     = r_full[6:0];
    cmd.px[0] = pen_x;
    cmd.py[0] = pen_y;
    cmd.px[1] = c1x;
    cmd.py[1] = c1y;
    cmd.px[2] = c2x;
    cmd.py[2] = c2y;
    cmd.px[3] = ex;
    cmd.py[3] = ey;
    unique case (bpf_pkg::action_t'(action))
      bpf_pkg::ACT_MOVE, bpf_pkg::ACT_LINE: begin
        // one segment at t = 1.0 lands exactly on the end point
        cmd.cs = (bpf_pkg::action_t'(action) == bpf_pkg::ACT_MOVE);
        cmd.n  = 7'd1;
        cmd.q  = 17'd65536;
        cmd.r  = '0;
      end
      bpf_pkg::ACT_QUAD: begin
        cmd.quad  = 1'b1;
        cmd.px[2] = ex;
        cmd.py[2] = ey;
      end
      bpf_pkg::ACT_CUBIC: begin
        cmd.quad = 1'b0;
      end
      default: begin
        cmd.quad = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segs  <= bpf_pkg::cnt_t'(bpf_pkg::SegsReset);
      pen_x <= 16'h8000;
      pen_y <= 16'h8000;
    end else begin
      if (segs_we) begin
        segs <= segs_data;
      end
      if (push) begin
        pen_x <= ex;
        pen_y <= ey;
      end
    end
  end

endmodule

@@ src/bpf_fifo.sv @@
module bpf_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bpf_pkg::cmd_t       din,
  input  logic                pop,
  output bpf_pkg::cmd_t       dout,
  output bpf_pkg::fifo_stat_t fstat
);

  bpf_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign fstat.full  = (count == 2'd2);
  assign fstat.valid = (count != 2'd0);
  assign dout        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ src/bpf_back.sv @@
module bpf_back (
  input  logic                clk,
  input  logic                rst,
  input  bpf_pkg::cmd_t       cmd,
  input  bpf_pkg::fifo_stat_t fstat,
  output logic                pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [23:0]  point_x,
  output logic signed [23:0]  point_y,
  output logic                contour_start,
  output logic                last_of_run
);

  bpf_pkg::cmd_t  cur;
  bpf_pkg::cnt_t  idx;
  bpf_pkg::tpar_t tacc;
  bpf_pkg::cnt_t  racc;

  logic           en;
  logic           issue;
  logic [7:0]     rsum;
  logic           carry;
  bpf_pkg::cnt_t  idx_next;
  bpf_pkg::tpar_t tacc_next;
  bpf_pkg::cnt_t  racc_next;
  logic           is_last;

  // pipeline: 1 t, 2 powers, 3 weights, 4 products, 5 pair sums, 6 output
  logic [5:1]           v;
  logic [2:1]           quad;
  logic [5:1]           cs;
  logic [5:1]           lst;
  bpf_pkg::coord_t [3:0] cx1, cy1, cx2, cy2, cx3, cy3;
  bpf_pkg::tpar_t       t1, t2, u2;
  logic [32:0]          tt2, uu2, ut2;
  bpf_pkg::weight_t [3:0] w3;
  bpf_pkg::sum_t [3:0]  px4, py4;
  bpf_pkg::sum_t [1:0]  sx5, sy5;

  logic [34:0]          uu3;
  logic [34:0]          tt3;
  logic [50:0]          m0, m1, m2, m3;
  bpf_pkg::weight_t [3:0] w_c;
  bpf_pkg::sum_t [3:0]  px_c, py_c;
  logic [64:0]          prx, pry;
  bpf_pkg::sum_t        fx, fy;

  assign en    = !(out_valid && out_stall);
  assign issue = busy && en;
  assign pop   = !busy && fstat.valid;

  always_comb begin
    rsum      = {1'b0, racc} + {1'b0, cur.r};
    carry     = (rsum >= {1'b0, cur.n});
    tacc_next = tacc + cur.q + {16'd0, carry};
    racc_next = carry ? bpf_pkg::cnt_t'(rsum - {1'b0, cur.n}) : rsum[6:0];
    idx_next  = idx + 7'd1;
    is_last   = (idx_next == cur.n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (issue && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= cmd;
      idx  <= '0;
      tacc <= '0;
      racc <= '0;
    end else if (issue) begin
      idx  <= idx_next;
      tacc <= tacc_next;
      racc <= racc_next;
    end
  end

  always_comb begin
    uu3 = {2'd0, uu2} + {1'b0, uu2, 1'b0};
    tt3 = {2'd0, tt2} + {1'b0, tt2, 1'b0};
    m0  = {18'd0, uu2} * {34'd0, u2};
    m1  = {16'd0, uu3} * {34'd0, t2};
    m2  = {16'd0, tt3} * {34'd0, u2};
    m3  = {18'd0, tt2} * {34'd0, t2};
    if (quad[2]) begin
      w_c[0] = {uu2[32:0], 16'd0};
      w_c[1] = {ut2[31:0], 17'd0};
      w_c[2] = {tt2[32:0], 16'd0};
      w_c[3] = '0;
    end else begin
      w_c[0] = m0[48:0];
      w_c[1] = m1[48:0];
      w_c[2] = m2[48:0];
      w_c[3] = m3[48:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prx      = {16'd0, w3[k]} * {49'd0, cx3[k]};
      pry      = {16'd0, w3[k]} * {49'd0, cy3[k]};
      px_c[k]  = prx[63:0];
      py_c[k]  = pry[63:0];
    end
  end

  // round half up at 8 fractional bits, then drop the offset
  assign fx = sx5[0] + sx5[1] + 64'h0000_0080_0000_0000;
  assign fy = sy5[0] + sy5[1] + 64'h0000_0080_0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[4:1], issue};
      out_valid <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad <= {quad[1], cur.quad};
      cs   <= {cs[4:1], cur.cs};
      lst  <= {lst[4:1], is_last};
      t1   <= tacc_next;
      cx1  <= cur.px;
      cy1  <= cur.py;
      t2   <= t1;
      u2   <= 17'd65536 - t1;
      tt2  <= 33'({16'd0, t1} * {16'd0, t1});
      uu2  <= 33'({16'd0, 17'd65536 - t1} * {16'd0, 17'd65536 - t1});
      ut2  <= 33'({16'd0, 17'd65536 - t1} * {16'd0, t1});
      cx2  <= cx1;
      cy2  <= cy1;
      w3   <= w_c;
      cx3  <= cx2;
      cy3  <= cy2;
      px4  <= px_c;
      py4  <= py_c;
      sx5[0] <= px4[0] + px4[1];
      sx5[1] <= px4[2] + px4[3];
      sy5[0] <= py4[0] + py4[1];
      sy5[1] <= py4[2] + py4[3];
      point_x       <= {~fx[63], fx[62:40]};
      point_y       <= {~fy[63], fy[62:40]};
      contour_start <= cs[5];
      last_of_run   <= lst[5];
    end
  end

endmodule

@@ src/bezier_path_flattener.sv @@
// Outline path flattener.
// Input channel (in_valid / in_stall): one path command per transfer, action
// move, line, quadratic or cubic with control and end points in font units.
// Output channel (out_valid / out_stall): vertices in signed 16.8 fixed
// point with contour_start on a move vertex and last_of_run on the final
// vertex of each command.
// segs_we / segs_data set the number of segments per curve (0 reads as 1,
// above 64 reads as 64); write it only while the block is idle.
// A two-entry command queue lies between the classifier, which keeps the pen
// and takes a command each cycle while the queue has room, and the evaluator.
// The evaluator loads a command while idle, then issues one vertex a cycle
// unless a presented vertex is stalled; a move or line gives one vertex, a
// curve n, through the single vertex-per-cycle evaluation pipeline.
// Reset clears the pen to the origin, the segment count to 8 and empties the
// queue and pipeline. While out_stall is high with a vertex presented, the
// issuing evaluator and pipeline hold and the presented vertex stays put;
// the queue then fills and in_stall rises.
module bezier_path_flattener (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [15:0] ctrl1_x,
  input  logic signed [15:0] ctrl1_y,
  input  logic signed [15:0] ctrl2_x,
  input  logic signed [15:0] ctrl2_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic               segs_we,
  input  logic [6:0]         segs_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] point_x,
  output logic signed [23:0] point_y,
  output logic               contour_start,
  output logic               last_of_run
);

  bpf_pkg::cmd_t       push_cmd;
  bpf_pkg::cmd_t       head_cmd;
  bpf_pkg::fifo_stat_t fstat;
  logic                push;
  logic                pop;
  logic                busy;

  bpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .ctrl1_x   (ctrl1_x),
    .ctrl1_y   (ctrl1_y),
    .ctrl2_x   (ctrl2_x),
    .ctrl2_y   (ctrl2_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .segs_we   (segs_we),
    .segs_data (segs_data),
    .fstat     (fstat),
    .push      (push),
    .cmd       (push_cmd)
  );

  bpf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .fstat (fstat)
  );

  bpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (head_cmd),
    .fstat         (fstat),
    .pop           (pop),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .contour_start (contour_start),
    .last_of_run   (last_of_run)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fstat.full)
    else $error("command queue written while full");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !busy && fstat.valid)
    else $error("command taken while evaluator busy or queue empty");

  a_move_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && contour_start |-> last_of_run)
    else $error("contour start vertex not the only vertex of its command");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy)
    else $error("evaluator not busy after loading a command");
`endif

endmodule
